### rtl/pwmd_pkg.sv
package pwmd_pkg;

	localparam int unsigned RX_W     = 8;
	localparam int unsigned TDATA_W  = 120;
	localparam int unsigned EVENT_W  = 3;

	localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;
	localparam logic [31:0] HAVE_PAYLOAD  = 32'd4;
	localparam logic [31:0] PIECE_HEADER  = 32'd8;
	// request and cancel carry this many payload bytes; they are skipped by stated length
	localparam logic [31:0] REQ_PAYLOAD   = 32'd12;

	localparam logic [7:0] ID_CHOKE    = 8'd0;
	localparam logic [7:0] ID_UNCHOKE  = 8'd1;
	localparam logic [7:0] ID_LAST_CTL = 8'd3;
	localparam logic [7:0] ID_HAVE     = 8'd4;
	localparam logic [7:0] ID_BITFIELD = 8'd5;
	localparam logic [7:0] ID_PIECE    = 8'd7;

	typedef enum logic [EVENT_W-1:0] {
		EV_KEEPALIVE = 3'd0,
		EV_CTRL_DONE = 3'd1,
		EV_HAVE      = 3'd2,
		EV_BF_BYTE   = 3'd3,
		EV_PIECE_HDR = 3'd4,
		EV_PIECE_BYTE = 3'd5,
		EV_OTHER_DONE = 3'd6,
		EV_ERROR     = 3'd7
	} event_t;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  id;
		logic [31:0] idx;
		logic [31:0] beg;
		logic [31:0] dlen;
		logic [7:0]  db;
		logic        last;
		logic        choked;
	} res_t;

endpackage

### rtl/pwmd_core.sv
module pwmd_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      beat,
	input  logic [pwmd_pkg::RX_W-1:0] rx_byte,
	input  logic [31:0]               max_len,
	output logic                      res_valid,
	output pwmd_pkg::res_t            res
);

	typedef enum logic [2:0] {
		PH_LEN, PH_ID, PH_HAVE, PH_PHDR, PH_DATA, PH_SKIP, PH_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] len_q, len_d;
	logic [31:0] rem_q, rem_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [7:0]  id_q, id_d;
	logic [31:0] word_q, word_d;
	logic [31:0] idx_q, idx_d;
	logic        choked_q, choked_d;

	logic [31:0] len_shift, word_shift, idx_shift, pay, rem_dec;

	assign len_shift  = {len_q[23:0], rx_byte};
	assign word_shift = {word_q[23:0], rx_byte};
	assign idx_shift  = {idx_q[23:0], rx_byte};
	assign pay        = len_q - 32'd1;
	assign rem_dec    = rem_q - 32'd1;

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		id_d      = id_q;
		word_d    = word_q;
		idx_d     = idx_q;
		choked_d  = choked_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_LEN: begin
				len_d = len_shift;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					cnt_d = 3'd0;
					if (len_shift == 32'd0) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_KEEPALIVE;
					end else if (len_shift > max_len) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_ERROR;
						phase_d   = PH_HALT;
					end else begin
						phase_d = PH_ID;
					end
				end
			end
			PH_ID: begin
				id_d   = rx_byte;
				len_d  = 32'd0;
				res.id = rx_byte;
				if (rx_byte <= pwmd_pkg::ID_LAST_CTL) begin
					if (rx_byte == pwmd_pkg::ID_CHOKE)   choked_d = 1'b1;
					if (rx_byte == pwmd_pkg::ID_UNCHOKE) choked_d = 1'b0;
					if (pay == 32'd0) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_CTRL_DONE;
						phase_d   = PH_LEN;
					end else begin
						rem_d   = pay;
						phase_d = PH_SKIP;
					end
				end else if (rx_byte == pwmd_pkg::ID_HAVE) begin
					if (pay != pwmd_pkg::HAVE_PAYLOAD) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_ERROR;
						phase_d   = PH_HALT;
					end else begin
						cnt_d   = 3'd0;
						word_d  = 32'd0;
						phase_d = PH_HAVE;
					end
				end else if (rx_byte == pwmd_pkg::ID_BITFIELD) begin
					if (pay == 32'd0) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_OTHER_DONE;
						phase_d   = PH_LEN;
					end else begin
						rem_d   = pay;
						phase_d = PH_DATA;
					end
				end else if (rx_byte == pwmd_pkg::ID_PIECE) begin
					if (pay < pwmd_pkg::PIECE_HEADER) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_ERROR;
						phase_d   = PH_HALT;
					end else begin
						rem_d   = pay - pwmd_pkg::PIECE_HEADER;
						cnt_d   = 3'd0;
						idx_d   = 32'd0;
						word_d  = 32'd0;
						phase_d = PH_PHDR;
					end
				end else begin
					if (pay == 32'd0) begin
						res_valid = 1'b1;
						res.ev    = pwmd_pkg::EV_OTHER_DONE;
						phase_d   = PH_LEN;
					end else begin
						rem_d   = pay;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_HAVE: begin
				word_d = word_shift;
				cnt_d  = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					cnt_d     = 3'd0;
					idx_d     = word_shift;
					phase_d   = PH_LEN;
					res_valid = 1'b1;
					res.ev    = pwmd_pkg::EV_HAVE;
					res.id    = id_q;
					res.idx   = word_shift;
				end
			end
			PH_PHDR: begin
				// first four bytes build the piece index, next four the begin offset
				if (!cnt_q[2]) idx_d = idx_shift;
				else           word_d = word_shift;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					phase_d   = (rem_q != 32'd0) ? PH_DATA : PH_LEN;
					res_valid = 1'b1;
					res.ev    = pwmd_pkg::EV_PIECE_HDR;
					res.id    = id_q;
					res.idx   = idx_q;
					res.beg   = word_shift;
					res.dlen  = rem_q;
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				if (rem_dec == 32'd0) phase_d = PH_LEN;
				res_valid = 1'b1;
				res.id    = id_q;
				res.dlen  = rem_dec;
				res.db    = rx_byte;
				res.last  = (rem_dec == 32'd0);
				if (id_q == pwmd_pkg::ID_PIECE) begin
					res.ev  = pwmd_pkg::EV_PIECE_BYTE;
					res.idx = idx_q;
					res.beg = word_q;
				end else begin
					res.ev  = pwmd_pkg::EV_BF_BYTE;
				end
			end
			PH_SKIP: begin
				rem_d = rem_dec;
				if (rem_dec == 32'd0) begin
					phase_d   = PH_LEN;
					res_valid = 1'b1;
					res.id    = id_q;
					res.ev    = (id_q <= pwmd_pkg::ID_LAST_CTL) ?
						pwmd_pkg::EV_CTRL_DONE : pwmd_pkg::EV_OTHER_DONE;
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
		res.choked = choked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			len_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			id_q     <= '0;
			word_q   <= '0;
			idx_q    <= '0;
			choked_q <= 1'b1;
		end else if (beat) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			cnt_q    <= cnt_d;
			id_q     <= id_d;
			word_q   <= word_d;
			idx_q    <= idx_d;
			choked_q <= choked_d;
		end
	end

endmodule

### rtl/peer_wire_message_deframer_unit.sv
// Peer wire message deframer.
// Slave stream (s_*) carries one received byte per beat. Each message is a
// 4-byte big-endian length, an id byte and its payload. The master stream
// (m_*) carries zero or one result beat per input byte: keepalive, control
// done, have index, bitfield byte, piece header, piece byte, other done, or
// error. m_tuser holds the event code, m_tlast marks the final data byte.
// A result is registered and appears on m_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parser state and the output register
// each take one short step per byte, so nothing limits the rate but the
// receiver. When the receiver stalls with a result held, s_tready follows
// m_tready, so a new byte is still taken in the cycle the held result leaves.
// Reset: parser waits for a length prefix, choked flag set, the largest
// accepted length is 16 MiB, output empty.
// After an error (oversize length, bad have length, short piece) bytes are
// still taken but dropped until reset.
// cfg_wr_en/cfg_wr_data write max_message_length; write only while idle.
module peer_wire_message_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [31:0]                   cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pwmd_pkg::RX_W-1:0]     s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] message_id, [39:8] piece_or_have_index, [71:40] block_begin,
	// [103:72] data_length, [111:104] data_byte, [112] choked_now, rest zero
	output logic [pwmd_pkg::TDATA_W-1:0]  m_tdata,
	output logic [pwmd_pkg::EVENT_W-1:0]  m_tuser,   // [2:0] event_res
	output logic                          m_tlast    // last_byte
);

	logic           beat;
	logic           res_valid;
	pwmd_pkg::res_t res;
	pwmd_pkg::res_t res_s1;
	logic           valid_s1;
	logic [31:0]    max_len_q;

	// Take a byte whenever the output slot is empty or being drained.
	assign s_tready = !valid_s1 || m_tready;
	assign beat     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= pwmd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	pwmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.rx_byte   (s_tdata),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load on an accepted byte, clear when drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (beat) begin
			valid_s1 <= res_valid;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat && res_valid) begin
			res_s1 <= res;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tuser  = res_s1.ev;
	assign m_tlast  = res_s1.last;
	assign m_tdata  = {7'd0, res_s1.choked, res_s1.db, res_s1.dlen,
		res_s1.beg, res_s1.idx, res_s1.id};

endmodule
